FILE: design/ubh_pkg.sv
// Shared constants, codes and types of the uniform bin histogram unit.
package ubh_pkg;

	localparam int UBH_MAX_BINS    = 1024;
	localparam int UBH_COUNT_WIDTH = 32;
	localparam int QDEPTH          = 2;   // power of two
	localparam int DIV_STEPS       = 32;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_SCAN  = 2'd3;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_RANGE  = 2'd1;
	localparam logic [1:0] STAT_NOBINS = 2'd2;

	localparam logic [1:0] REG_BINS   = 2'd0;
	localparam logic [1:0] REG_BOTTOM = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;

	typedef enum logic [2:0] {
		K_NOBIN,
		K_UNDER,
		K_ADD,
		K_CLEAR,
		K_RDBAD,
		K_READ,
		K_SCAN,
		K_SCAN0
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] sample;
		logic [31:0] diff;
		logic [9:0]  idx;
	} op_t;

endpackage

FILE: design/ubh_div.sv
// Restoring divider, one quotient bit per cycle.
module ubh_div import ubh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [30:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic        run_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [30:0] rem_q;
	logic [31:0] dvd_q;
	logic [30:0] dvs_q;
	logic [31:0] trial;
	logic [31:0] diff;
	logic        ge;

	always_comb begin
		trial = {rem_q, dvd_q[31]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'(DIV_STEPS);
				rem_q <= '0;
				dvd_q <= dividend;
				dvs_q <= divisor;
			end else if (run_q) begin
				rem_q <= ge ? diff[30:0] : trial[30:0];
				dvd_q <= {dvd_q[30:0], ge};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

FILE: design/ubh_fifo.sv
// Short command queue between the front end and the engine.
module ubh_fifo import ubh_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic empty,
	output op_t  head
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	op_t           ent_q [QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == CW'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

FILE: design/ubh_front.sv
// Input stage: takes commands and classifies them against the bin layout.
module ubh_front import ubh_pkg::*; #(
	parameter  int MAX_BINS = UBH_MAX_BINS,
	localparam int NBW      = $clog2(MAX_BINS + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [1:0]     cmd,
	input  logic [31:0]    sample,
	input  logic [9:0]     bin_index,
	input  logic [NBW-1:0] nb,
	input  logic [31:0]    bottom,
	input  logic           hold,
	output logic           q_push,
	output op_t            q_op,
	input  logic           q_full
);

	logic        valid_s1;
	op_t         op_s1;
	op_t         op_d;
	logic [32:0] delta;
	logic        take;

	always_comb begin
		delta       = {sample[31], sample} - {bottom[31], bottom};
		op_d.sample = sample;
		op_d.diff   = delta[31:0];
		op_d.idx    = bin_index;
		unique case (cmd)
			CMD_ADD: begin
				if (nb == '0) begin
					op_d.kind = K_NOBIN;
				end else if (delta[32]) begin
					op_d.kind = K_UNDER;
				end else begin
					op_d.kind = K_ADD;
				end
			end
			CMD_CLEAR: op_d.kind = K_CLEAR;
			CMD_READ: begin
				op_d.kind = (32'(bin_index) >= 32'(nb)) ? K_RDBAD : K_READ;
			end
			default: op_d.kind = (nb == '0) ? K_SCAN0 : K_SCAN;
		endcase
	end

	assign full   = hold || (valid_s1 && q_full);
	assign take   = push && !full;
	assign q_push = valid_s1;
	assign q_op   = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= op_d;
		end
	end

endmodule

FILE: design/ubh_back.sv
// Engine: bin memory, divider, scan and clear sweeps, statistics and result register.
module ubh_back import ubh_pkg::*; #(
	parameter  int MAX_BINS    = UBH_MAX_BINS,
	parameter  int COUNT_WIDTH = UBH_COUNT_WIDTH,
	localparam int NBW         = $clog2(MAX_BINS + 1),
	localparam int AW          = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_clr,
	input  logic [NBW-1:0]        nb,
	input  logic [30:0]           width_eff,
	input  logic                  q_empty,
	input  op_t                   q_head,
	output logic                  q_pop,
	output logic                  init_busy,
	output logic                  empty,
	input  logic                  pop,
	output logic [1:0]            status,
	output logic [31:0]           bin_value,
	output logic [31:0]           total_count,
	output logic [31:0]           largest_bin,
	output logic [31:0]           smallest_bin,
	output logic signed [31:0]    min_sample,
	output logic signed [31:0]    max_sample,
	output logic [31:0]           below_count,
	output logic [31:0]           above_count,
	output logic                  no_samples
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_RD   = 6'b000100,
		ST_USE  = 6'b001000,
		ST_SCAN = 6'b010000,
		ST_CLR  = 6'b100000
	} bstate_t;

	function automatic logic [31:0] to_out(input logic [COUNT_WIDTH-1:0] v);
		logic [COUNT_WIDTH+31:0] ext;
		ext = {32'd0, v};
		if (ext > {{COUNT_WIDTH{1'b0}}, 32'hFFFF_FFFF}) begin
			to_out = 32'hFFFF_FFFF;
		end else begin
			to_out = ext[31:0];
		end
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		sat_inc = (v == '1) ? v : v + COUNT_WIDTH'(1);
	endfunction

	logic [COUNT_WIDTH-1:0] mem [MAX_BINS];
	logic [COUNT_WIDTH-1:0] rd_q;

	bstate_t                state_q;
	logic                   init_q;
	op_t                    op_q;
	logic [AW-1:0]          kaddr_q;
	logic [NBW-1:0]         cnt_q;
	logic                   dv_s1;
	logic                   first_q;
	logic [COUNT_WIDTH-1:0] tot_q;
	logic [COUNT_WIDTH-1:0] hi_q;
	logic [COUNT_WIDTH-1:0] lo_q;
	logic [31:0]            lowest_q;
	logic [31:0]            highest_q;
	logic                   empty_q;
	logic [COUNT_WIDTH-1:0] under_q;
	logic [COUNT_WIDTH-1:0] over_q;

	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic [31:0]            bval_q;
	logic [31:0]            total_q;
	logic [31:0]            large_q;
	logic [31:0]            small_q;

	logic                   start;
	logic                   div_start;
	logic                   div_done;
	logic [31:0]            quot;
	logic [AW-1:0]          raddr;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [COUNT_WIDTH-1:0] wdata;
	logic [COUNT_WIDTH:0]   sum;
	logic                   issue;

	ubh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (q_head.diff),
		.divisor  (width_eff),
		.done     (div_done),
		.quotient (quot)
	);

	always_comb begin
		start     = (state_q == ST_IDLE) && !q_empty && !out_valid_q && !cfg_clr;
		q_pop     = start;
		div_start = start && (q_head.kind == K_ADD);
		issue     = cnt_q != nb;
		sum       = {1'b0, tot_q} + {1'b0, rd_q};
		raddr     = (state_q == ST_SCAN) ? cnt_q[AW-1:0] : kaddr_q;
		we        = 1'b0;
		waddr     = kaddr_q;
		wdata     = sat_inc(rd_q);
		if (state_q == ST_USE && op_q.kind == K_ADD) begin
			we = 1'b1;
		end else if (state_q == ST_CLR) begin
			we    = 1'b1;
			waddr = cnt_q[AW-1:0];
			wdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			init_q      <= 1'b1;
			op_q        <= '0;
			kaddr_q     <= '0;
			cnt_q       <= '0;
			dv_s1       <= 1'b0;
			first_q     <= 1'b0;
			tot_q       <= '0;
			hi_q        <= '0;
			lo_q        <= '0;
			lowest_q    <= '0;
			highest_q   <= '0;
			empty_q     <= 1'b1;
			under_q     <= '0;
			over_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STAT_OK;
			bval_q      <= '0;
			total_q     <= '0;
			large_q     <= '0;
			small_q     <= '0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_clr) begin
				state_q   <= ST_CLR;
				init_q    <= 1'b1;
				cnt_q     <= '0;
				lowest_q  <= '0;
				highest_q <= '0;
				empty_q   <= 1'b1;
				under_q   <= '0;
				over_q    <= '0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (start) begin
							op_q     <= q_head;
							kaddr_q  <= AW'(q_head.idx);
							status_q <= STAT_OK;
							bval_q   <= '0;
							total_q  <= '0;
							large_q  <= '0;
							small_q  <= '0;
							if (q_head.kind == K_UNDER || q_head.kind == K_ADD) begin
								if (empty_q) begin
									lowest_q  <= q_head.sample;
									highest_q <= q_head.sample;
									empty_q   <= 1'b0;
								end else begin
									if ($signed(q_head.sample) < $signed(lowest_q)) begin
										lowest_q <= q_head.sample;
									end
									if ($signed(q_head.sample) > $signed(highest_q)) begin
										highest_q <= q_head.sample;
									end
								end
							end
							unique case (q_head.kind)
								K_NOBIN: begin
									status_q    <= STAT_NOBINS;
									out_valid_q <= 1'b1;
								end
								K_UNDER: begin
									under_q     <= sat_inc(under_q);
									out_valid_q <= 1'b1;
								end
								K_ADD: state_q <= ST_DIV;
								K_CLEAR: begin
									init_q    <= 1'b0;
									cnt_q     <= '0;
									lowest_q  <= '0;
									highest_q <= '0;
									empty_q   <= 1'b1;
									under_q   <= '0;
									over_q    <= '0;
									state_q   <= ST_CLR;
								end
								K_RDBAD: begin
									status_q    <= STAT_RANGE;
									out_valid_q <= 1'b1;
								end
								K_READ: state_q <= ST_RD;
								K_SCAN: begin
									cnt_q   <= '0;
									dv_s1   <= 1'b0;
									first_q <= 1'b1;
									state_q <= ST_SCAN;
								end
								K_SCAN0: out_valid_q <= 1'b1;
							endcase
						end
					end
					ST_DIV: begin
						if (div_done) begin
							if (quot >= 32'(nb)) begin
								over_q      <= sat_inc(over_q);
								out_valid_q <= 1'b1;
								state_q     <= ST_IDLE;
							end else begin
								kaddr_q <= quot[AW-1:0];
								state_q <= ST_RD;
							end
						end
					end
					ST_RD: state_q <= ST_USE;
					ST_USE: begin
						if (op_q.kind == K_READ) begin
							bval_q <= to_out(rd_q);
						end
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
					ST_SCAN: begin
						dv_s1 <= issue;
						if (issue) begin
							cnt_q <= cnt_q + NBW'(1);
						end
						if (dv_s1) begin
							first_q <= 1'b0;
							if (first_q) begin
								tot_q <= rd_q;
								hi_q  <= rd_q;
								lo_q  <= rd_q;
							end else begin
								tot_q <= sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
								if (rd_q > hi_q) begin
									hi_q <= rd_q;
								end
								if (rd_q < lo_q) begin
									lo_q <= rd_q;
								end
							end
						end
						if (!issue && !dv_s1) begin
							total_q     <= to_out(tot_q);
							large_q     <= to_out(hi_q);
							small_q     <= to_out(lo_q);
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end
					ST_CLR: begin
						cnt_q <= cnt_q + NBW'(1);
						if (cnt_q == NBW'(MAX_BINS - 1)) begin
							state_q <= ST_IDLE;
							if (!init_q) begin
								out_valid_q <= 1'b1;
							end
							init_q <= 1'b0;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign init_busy    = (state_q == ST_CLR) && init_q;
	assign empty        = !out_valid_q;
	assign status       = status_q;
	assign bin_value    = bval_q;
	assign total_count  = total_q;
	assign largest_bin  = large_q;
	assign smallest_bin = small_q;
	assign min_sample   = lowest_q;
	assign max_sample   = highest_q;
	assign below_count  = to_out(under_q);
	assign above_count  = to_out(over_q);
	assign no_samples   = empty_q;

endmodule

FILE: design/uniform_bin_histogram_unit.sv
// Top level of the uniform bin histogram unit: configuration registers and block wiring.
//
//   channel   handshake               payload
//   command   push / full             cmd, sample, bin_index
//   result    empty / pop             status, bin_value, total_count, largest_bin,
//                                     smallest_bin, min_sample, max_sample,
//                                     below_count, above_count, no_samples
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The front register and the queue lie ahead of the engine, which takes one command off the
// queue at a time. An add in range runs the one-bit-per-cycle divider (32 steps) and then a
// read-modify-write of the bin memory; an add above range runs the divider and counts it in
// above_count; an add below range or without bins needs neither the divider nor the memory.
// A read reads one bin; a scan reads one bin per cycle over the active bins; a clear zeroes all MAX_BINS.
// After reset and after any register write the bin memory is swept to zero; full stays high
// meanwhile. A two-entry queue lets commands enter while a result waits.
module uniform_bin_histogram_unit import ubh_pkg::*; #(
	parameter int MAX_BINS    = UBH_MAX_BINS,
	parameter int COUNT_WIDTH = UBH_COUNT_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] sample,
	input  logic [9:0]         bin_index,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         status,
	output logic [31:0]        bin_value,
	output logic [31:0]        total_count,
	output logic [31:0]        largest_bin,
	output logic [31:0]        smallest_bin,
	output logic signed [31:0] min_sample,
	output logic signed [31:0] max_sample,
	output logic [31:0]        below_count,
	output logic [31:0]        above_count,
	output logic               no_samples,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int NBW = $clog2(MAX_BINS + 1);

	logic [10:0]    bins_q;
	logic [31:0]    bottom_q;
	logic [30:0]    width_q;
	logic           cfg_clr;
	logic [NBW-1:0] nb;
	logic [30:0]    width_eff;
	logic           hold;
	logic           q_push;
	op_t            q_op;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;
	op_t            q_head;

	assign cfg_ready = 1'b1;

	always_comb begin
		unique case (cfg_index)
			REG_BINS, REG_BOTTOM, REG_WIDTH: cfg_clr = cfg_valid;
			default: cfg_clr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q   <= '0;
			bottom_q <= '0;
			width_q  <= 31'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BINS:   bins_q   <= cfg_data[10:0];
				REG_BOTTOM: bottom_q <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(bins_q) > 32'(MAX_BINS)) begin
			nb = NBW'(MAX_BINS);
		end else begin
			nb = NBW'(bins_q);
		end
		width_eff = (width_q == '0) ? 31'd1 : width_q;
	end

	ubh_front #(
		.MAX_BINS (MAX_BINS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.sample    (sample),
		.bin_index (bin_index),
		.nb        (nb),
		.bottom    (bottom_q),
		.hold      (hold),
		.q_push    (q_push),
		.q_op      (q_op),
		.q_full    (q_full)
	);

	ubh_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_op),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head    (q_head)
	);

	ubh_back #(
		.MAX_BINS    (MAX_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_clr      (cfg_clr),
		.nb           (nb),
		.width_eff    (width_eff),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.init_busy    (hold),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.bin_value    (bin_value),
		.total_count  (total_count),
		.largest_bin  (largest_bin),
		.smallest_bin (smallest_bin),
		.min_sample   (min_sample),
		.max_sample   (max_sample),
		.below_count  (below_count),
		.above_count  (above_count),
		.no_samples   (no_samples)
	);

endmodule
